// File: rtl/amcb_pkg.sv
// ----------------------------------------------------------------------------
// amcb_pkg
// Shared types, constants and the control store of the assignment search.
// ----------------------------------------------------------------------------
package amcb_pkg;

    // Stream widths: fields packed from bit 0 and padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int COST_W      = 16;
    localparam int SIZE_W      = 4;
    localparam int SUM_W       = 20;
    localparam int OUT_W       = 19;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

    // Running-minimum start value and the result saturation bounds.
    localparam logic signed [SUM_W-1:0] BEST_RESET = SUM_W'(524287);
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(262143);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SUM_W'(262144);

    // Program counter of the sequencer.
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_RD_PERM,
        OP_ACC,
        OP_BEST,
        OP_GRAB,
        OP_SWAP,
        OP_ADV,
        OP_OUT
    } op_t;

    // Jump conditions; when the condition fails the counter steps on.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOSTART,
        C_W_MORE,
        C_I_DONE,
        C_CNT_GE,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_t;

    // Status flags handed from the datapath back to the sequencer.
    typedef struct packed {
        logic start;
        logic w_more;
        logic i_done;
        logic cnt_ge;
        logic out_full;
    } stat_t;

    // Step addresses of the program.
    localparam pc_t S_IDLE  = PC_W'(0);
    localparam pc_t S_INIT  = PC_W'(1);
    localparam pc_t S_RPERM = PC_W'(2);
    localparam pc_t S_RCOST = PC_W'(3);
    localparam pc_t S_ACC   = PC_W'(4);
    localparam pc_t S_BEST  = PC_W'(5);
    localparam pc_t S_LOOP  = PC_W'(6);
    localparam pc_t S_TEST  = PC_W'(7);
    localparam pc_t S_GRAB  = PC_W'(8);
    localparam pc_t S_SWAP  = PC_W'(9);
    localparam pc_t S_ADV   = PC_W'(10);
    localparam pc_t S_DONE  = PC_W'(11);
    localparam pc_t S_RET   = PC_W'(12);

    // Control store: scoring of one permutation, then one Heap step.
    function automatic uword_t urom(input pc_t pc);
        uword_t w;
        unique case (pc)
            S_IDLE:  w = '{op: OP_NOP,     cond: C_NOSTART,  target: S_IDLE};
            S_INIT:  w = '{op: OP_INIT,    cond: C_NEXT,     target: S_IDLE};
            S_RPERM: w = '{op: OP_RD_PERM, cond: C_NEXT,     target: S_IDLE};
            S_RCOST: w = '{op: OP_NOP,     cond: C_NEXT,     target: S_IDLE};
            S_ACC:   w = '{op: OP_ACC,     cond: C_W_MORE,   target: S_RPERM};
            S_BEST:  w = '{op: OP_BEST,    cond: C_NEXT,     target: S_IDLE};
            S_LOOP:  w = '{op: OP_NOP,     cond: C_I_DONE,   target: S_DONE};
            S_TEST:  w = '{op: OP_NOP,     cond: C_CNT_GE,   target: S_ADV};
            S_GRAB:  w = '{op: OP_GRAB,    cond: C_NEXT,     target: S_IDLE};
            S_SWAP:  w = '{op: OP_SWAP,    cond: C_ALWAYS,   target: S_RPERM};
            S_ADV:   w = '{op: OP_ADV,     cond: C_ALWAYS,   target: S_LOOP};
            S_DONE:  w = '{op: OP_OUT,     cond: C_OUT_FULL, target: S_DONE};
            S_RET:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
            default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

    // Clamp the running minimum to the result range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[OUT_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/assignment_min_cost_bruteforce.sv
// ----------------------------------------------------------------------------
// assignment_min_cost_bruteforce
// Exhaustive minimum-cost assignment over a loaded square cost matrix.
// ----------------------------------------------------------------------------
// Matrix entries are loaded one beat per cycle into a cost store of
// MAX_SIDE*MAX_SIDE words. The beat carrying tlast is stored and then starts
// the search; s_tready stays low until the result has been placed in the
// output register. The search walks all n! permutations of the side in use
// (Heap's method), each scored by reading n entries through the single read
// port of the cost store: for each entry the sequencer reads the permutation
// register, waits for the registered store read and accumulates, and after
// the last entry it updates the running minimum before the next Heap step.
// A finished result may wait in the output register while new entries load.
// ----------------------------------------------------------------------------
module assignment_min_cost_bruteforce
    import amcb_pkg::*;
#(
    parameter int MAX_SIDE = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // row [2:0], col [5:3], cost_value [21:6], zero [23:22]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // least_cost [18:0], zero [23:19]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SIZE_W-1:0]      cfg_data
);

    ctrl_t            ctrl;
    stat_t            stat;
    logic [OUT_W-1:0] m_data;

    amcb_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    amcb_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_data    (m_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

    // Input is open only while the sequencer idles.
    assign s_tready  = ctrl.idle;
    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(OUT_TDATA_W - OUT_W){1'b0}}, m_data};

endmodule

// File: rtl/amcb_ram.sv
// ----------------------------------------------------------------------------
// amcb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/amcb_useq.sv
// ----------------------------------------------------------------------------
// amcb_useq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module amcb_useq
    import amcb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctrl_t ctrl
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   take;

    assign uw = urom(pc_reg);

    // Evaluate the jump condition of the current word.
    always_comb begin
        unique case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NOSTART:  take = !stat.start;
            C_W_MORE:   take = stat.w_more;
            C_I_DONE:   take = stat.i_done;
            C_CNT_GE:   take = stat.cnt_ge;
            C_OUT_FULL: take = stat.out_full;
            default:    take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + PC_W'(1);
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.idle = (pc_reg == S_IDLE);

endmodule

// File: rtl/amcb_dpath.sv
// ----------------------------------------------------------------------------
// amcb_dpath
// Datapath: cost store, permutation and counter registers, accumulator,
// running minimum and the result register.
// ----------------------------------------------------------------------------
module amcb_dpath
    import amcb_pkg::*;
#(
    parameter int MAX_SIDE = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_t                  ctrl,
    output stat_t                  stat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    input  logic                   cfg_valid,
    input  logic [SIZE_W-1:0]      cfg_data,
    output logic [OUT_W-1:0]       m_data,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    localparam int PW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [COST_W-1:0] in_cost;
    logic              s_fire;
    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [AW-1:0]     st_raddr;
    logic [COST_W-1:0] st_rdata;

    logic [SIZE_W-1:0] size_reg;
    logic [CW-1:0]     n_side;
    logic [CW-1:0]     n_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     w_reg;
    logic [PW-1:0]     i_idx;
    logic [PW-1:0]     k_sel;
    logic [PW-1:0]     k_reg;
    logic [PW-1:0]     t_reg;
    logic [PW-1:0]     pr_reg;
    logic [PW-1:0]     prd_sel;
    logic [PW-1:0]     perm_rd;
    logic [PW-1:0]     perm_reg [MAX_SIDE];
    logic [CW-1:0]     cnt_reg  [MAX_SIDE];

    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] best_reg;
    logic signed [SUM_W-1:0] cost_ext;
    logic [OUT_W-1:0]        m_data_reg;
    logic                    m_valid_reg;
    logic                    out_full;
    logic                    out_load;

    // Unpack the input beat.
    assign in_row  = s_tdata[ROW_W-1:0];
    assign in_col  = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_cost = s_tdata[ROW_W+COL_W+COST_W-1:ROW_W+COL_W];
    assign s_fire  = s_tvalid && ctrl.idle;

    // Entries outside the store are dropped.
    assign st_we    = s_fire && (int'(in_row) < MAX_SIDE) && (int'(in_col) < MAX_SIDE);
    assign st_waddr = AW'(int'(in_row) * MAX_SIDE + int'(in_col));
    assign st_raddr = AW'(int'(w_reg) * MAX_SIDE + int'(pr_reg));

    amcb_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (in_cost),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Size register and its clamp to the legal side range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_valid) begin
            size_reg <= cfg_data;
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            n_side = CW'(1);
        end else if (int'(size_reg) > MAX_SIDE) begin
            n_side = CW'(MAX_SIDE);
        end else begin
            n_side = CW'(size_reg);
        end
    end

    // Single read port on the permutation registers, address chosen by step.
    assign i_idx = i_reg[PW-1:0];
    assign k_sel = i_reg[0] ? cnt_reg[i_idx][PW-1:0] : '0;

    always_comb begin
        unique case (ctrl.op)
            OP_GRAB: prd_sel = k_sel;
            OP_SWAP: prd_sel = i_idx;
            default: prd_sel = w_reg[PW-1:0];
        endcase
    end

    assign perm_rd  = perm_reg[prd_sel];
    assign cost_ext = SUM_W'(signed'(st_rdata));
    assign out_full = m_valid_reg && !m_tready;
    assign out_load = (ctrl.op == OP_OUT) && !out_full;

    // Search datapath, one operation per step.
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_INIT: begin
                for (int x = 0; x < MAX_SIDE; x++) begin
                    perm_reg[x] <= PW'(x);
                    cnt_reg[x]  <= '0;
                end
                best_reg <= BEST_RESET;
                acc_reg  <= '0;
                i_reg    <= CW'(1);
                w_reg    <= '0;
                n_reg    <= n_side;
            end
            OP_RD_PERM: begin
                pr_reg <= perm_rd;
            end
            OP_ACC: begin
                acc_reg <= acc_reg + cost_ext;
                w_reg   <= w_reg + CW'(1);
            end
            OP_BEST: begin
                if (acc_reg < best_reg) begin
                    best_reg <= acc_reg;
                end
                acc_reg <= '0;
                w_reg   <= '0;
            end
            OP_GRAB: begin
                t_reg <= perm_rd;
                k_reg <= k_sel;
            end
            OP_SWAP: begin
                perm_reg[k_reg] <= perm_rd;
                perm_reg[i_idx] <= t_reg;
                cnt_reg[i_idx]  <= cnt_reg[i_idx] + CW'(1);
                i_reg           <= CW'(1);
            end
            OP_ADV: begin
                cnt_reg[i_idx] <= '0;
                i_reg          <= i_reg + CW'(1);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_data_reg <= sat_out(best_reg);
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Status back to the sequencer.
    assign stat.start    = s_fire && s_tlast;
    assign stat.w_more   = (int'(w_reg) + 1) < int'(n_reg);
    assign stat.i_done   = (i_reg >= n_reg);
    assign stat.cnt_ge   = (cnt_reg[i_idx] >= i_reg);
    assign stat.out_full = out_full;

    assign m_data   = m_data_reg;
    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/amcb_chk.sv
// ----------------------------------------------------------------------------
// amcb_chk
// Port-level checks of the assignment search, bound to the top level.
// ----------------------------------------------------------------------------
module amcb_chk
    import amcb_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // A beat without tlast only loads the store, so input stays open.
    a_load_keeps_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> s_tready)
        else $error("input closed after a plain load beat");

    // The tlast beat starts a search and closes the input.
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after the tlast beat");

    // A new result only appears at the end of a search.
    a_result_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while the block was idle");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind assignment_min_cost_bruteforce amcb_chk u_amcb_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the brute-force minimum-cost assignment block.
// ----------------------------------------------------------------------------
// Cost matrices are streamed in as entry beats. Each beat marked last is
// followed by a predicted minimum cost, which this bench works out by dynamic
// programming over subsets of jobs. It then compares each result beat with the
// oldest prediction. A short directed part covers the field extremes, the
// side register's edge values and a full eight-by-eight search. Random frames
// follow, mostly complete matrices in shuffled order, some with stray entries
// mixed in, the rest truncated frames. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb
    import amcb_pkg::*;
();

    localparam int SIDE_MAX      = 8;
    localparam int STORE_DEPTH   = SIDE_MAX * SIDE_MAX;
    localparam int ITEM_TARGET   = 1100;
    localparam int STALL_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LEAST_COST_HI = 262143;
    localparam int LEAST_COST_LO = -262144;

    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic signed [COST_W-1:0] cost;
        logic                     last;
    } entry_beat_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    // row [2:0], col [5:3], cost_value [21:6], zero [23:22]
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // least_cost [18:0], zero [23:19]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [SIZE_W-1:0]      cfg_data  = '0;

    entry_beat_t              beat_q[$];
    logic [OUT_W-1:0]         result_q[$];
    logic signed [COST_W-1:0] cost_mem [0:STORE_DEPTH-1];
    logic [SIZE_W-1:0]        side_reg = SIZE_RESET;
    entry_beat_t              cur_beat;
    int                       in_gap      = 0;
    int                       out_gap     = 0;
    bit                       calm        = 1'b0;
    int                       mismatches  = 0;
    int                       items_sent  = 0;
    int                       idle_cycles = 0;

    assignment_min_cost_bruteforce #(
        .MAX_SIDE(SIDE_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none in a calm phase.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random cost with the corner values weighted up.
    function automatic logic signed [COST_W-1:0] rand_cost();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return '1;
            default: return COST_W'($urandom);
        endcase
    endfunction

    // A side of zero acts as one; anything above the store side is clamped.
    function automatic int side_in_use(input logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > SIDE_MAX) return SIDE_MAX;
        return int'(v);
    endfunction

    // Minimum assignment cost: workers are placed in order and the mask
    // records which jobs are already taken.
    function automatic logic [OUT_W-1:0] predict_least_cost(input int side);
        int best [0:(1 << SIDE_MAX) - 1];
        int full;
        int mask;
        int worker;
        int job;
        int cand;
        full = (1 << side) - 1;
        for (mask = 0; mask <= full; mask++) best[mask] = 32'sh3FFF_FFFF;
        best[0] = 0;
        for (mask = 0; mask < full; mask++) begin
            worker = $countones(mask);
            for (job = 0; job < side; job++) begin
                if (((mask >> job) & 1) == 0) begin
                    cand = best[mask] + int'(cost_mem[worker * SIDE_MAX + job]);
                    if (cand < best[mask | (1 << job)]) best[mask | (1 << job)] = cand;
                end
            end
        end
        cand = best[full];
        if (cand > LEAST_COST_HI) cand = LEAST_COST_HI;
        if (cand < LEAST_COST_LO) cand = LEAST_COST_LO;
        return cand[OUT_W-1:0];
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t ns: %s", $time, what);
    endtask

    task automatic push_beat(input int row, input int col,
                             input logic signed [COST_W-1:0] cost, input bit last);
        entry_beat_t b;
        b.row  = ROW_W'(row);
        b.col  = COL_W'(col);
        b.cost = cost;
        b.last = last;
        beat_q.push_back(b);
        items_sent++;
    endtask

    // A complete side-by-side matrix in shuffled order, last on the final cell.
    task automatic load_matrix(input int side, input bit with_strays);
        int order [0:STORE_DEPTH-1];
        int cells;
        int k;
        int pick;
        int tmp;
        cells = side * side;
        for (k = 0; k < cells; k++) order[k] = k;
        for (k = cells - 1; k > 0; k--) begin
            pick        = $urandom_range(0, k);
            tmp         = order[k];
            order[k]    = order[pick];
            order[pick] = tmp;
        end
        for (k = 0; k < cells; k++) begin
            if (with_strays && $urandom_range(0, 9) == 0) begin
                push_beat($urandom_range(0, 7), $urandom_range(0, 7), rand_cost(), 1'b0);
            end
            push_beat(order[k] / side, order[k] % side, rand_cost(), k == cells - 1);
        end
    endtask

    // Idle means nothing queued, nothing on the bus and nothing outstanding;
    // sampled on the falling edge so that every update of the edge is seen.
    task automatic wait_idle();
        do @(negedge aclk);
        while (beat_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_side(input logic [SIZE_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        side_reg   = v;
        cfg_valid <= 1'b0;
        calm       = ($urandom_range(0, 3) == 0);
    endtask

    // Entry driver: presents queued beats and updates the prediction as each
    // one is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cost_mem[{cur_beat.row, cur_beat.col}] = cur_beat.cost;
                if (cur_beat.last) begin
                    result_q.push_back(predict_least_cost(side_in_use(side_reg)));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    cur_beat  = beat_q.pop_front();
                    in_gap    = pick_gap();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'({cur_beat.cost, cur_beat.col, cur_beat.row});
                    s_tlast  <= cur_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin : result_monitor
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    note_mismatch($sformatf("least cost %0d with no prediction pending",
                                            $signed(m_tdata[OUT_W-1:0])));
                end else begin
                    want = result_q.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want) begin
                        note_mismatch($sformatf("least cost %0d, predicted %0d",
                                                $signed(m_tdata[OUT_W-1:0]), $signed(want)));
                    end
                    if (m_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
                        note_mismatch($sformatf("result padding 0x%0h is not zero",
                                                m_tdata[OUT_TDATA_W-1:OUT_W]));
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles in which no beat of any channel is accepted.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("assignment_min_cost_bruteforce verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                perm [0:SIDE_MAX-1];
        int                k;
        int                pick;
        int                tmp;
        int                r;
        int                c;
        int                roll;
        int                side;
        int                frames;
        int                f;
        int                n_beats;
        int                sevens;
        logic [SIZE_W-1:0] size_val;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Side of three from reset, with every corner value of the cost field.
        push_beat(0, 0, 16'sh8000, 1'b0);
        push_beat(0, 1, 16'sh7FFF, 1'b0);
        push_beat(0, 2, 16'sh0000, 1'b0);
        push_beat(1, 0, 16'shFFFF, 1'b0);
        push_beat(1, 1, 16'sh7FFF, 1'b0);
        push_beat(1, 2, 16'sh8000, 1'b0);
        push_beat(2, 0, 16'sh0001, 1'b0);
        push_beat(2, 1, 16'sh5555, 1'b0);
        push_beat(2, 2, 16'shAAAA, 1'b1);

        // Side of one; an unmarked beat in between gives no result.
        write_side(SIZE_W'(1));
        push_beat(0, 0, 16'sh8000, 1'b1);
        push_beat(7, 7, 16'sh7FFF, 1'b0);
        push_beat(0, 0, 16'sh3039, 1'b1);

        // A side of zero behaves as a side of one.
        write_side(SIZE_W'(0));
        push_beat(0, 0, 16'sh7FFF, 1'b1);

        // Side of two over an entry left from the previous frame.
        write_side(SIZE_W'(2));
        push_beat(1, 1, 16'sh8000, 1'b0);
        push_beat(0, 1, 16'sh7FFF, 1'b0);
        push_beat(1, 0, 16'sh7FFF, 1'b1);

        // Register at its top value, clamped to the full side: one hidden
        // permutation of most negative costs gives the lowest possible result.
        write_side(SIZE_W'(15));
        for (k = 0; k < SIDE_MAX; k++) perm[k] = k;
        for (k = SIDE_MAX - 1; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            tmp        = perm[k];
            perm[k]    = perm[pick];
            perm[pick] = tmp;
        end
        for (r = 0; r < SIDE_MAX; r++) begin
            for (c = 0; c < SIDE_MAX; c++) begin
                push_beat(r, c, (perm[r] == c) ? 16'sh8000 : rand_cost(),
                          r == SIDE_MAX - 1 && c == SIDE_MAX - 1);
            end
        end

        // Random phases: small sides most of the time, the slow ones rarely.
        sevens = 0;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                size_val = SIZE_W'(0);
            end else if (roll < 12) begin
                size_val = SIZE_W'(1);
            end else if (roll < 30) begin
                size_val = SIZE_W'(2);
            end else if (roll < 55) begin
                size_val = SIZE_W'(3);
            end else if (roll < 78) begin
                size_val = SIZE_W'(4);
            end else if (roll < 92) begin
                size_val = SIZE_W'(5);
            end else if (roll < 98 || sevens > 0) begin
                size_val = SIZE_W'(6);
            end else begin
                size_val = SIZE_W'(7);
                sevens++;
            end
            side = side_in_use(size_val);
            if (side == 7) begin
                frames = 1;
            end else if (side == 6) begin
                frames = $urandom_range(1, 2);
            end else begin
                frames = $urandom_range(2, 6);
            end
            write_side(size_val);
            for (f = 0; f < frames; f++) begin
                if ($urandom_range(0, 6) == 0) begin
                    // Truncated frame: one to side*side + 2 entries anywhere, the last one marked.
                    n_beats = $urandom_range(1, side * side + 2);
                    for (k = 0; k < n_beats; k++) begin
                        push_beat($urandom_range(0, 7), $urandom_range(0, 7), rand_cost(),
                                  k == n_beats - 1);
                    end
                end else begin
                    load_matrix(side, $urandom_range(0, 1));
                end
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("assignment_min_cost_bruteforce verification clean");
        end else begin
            $display("assignment_min_cost_bruteforce verification failed");
        end
        $finish;
    end

endmodule
